FILE: hdl/mpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Max priority queue package
// Shared types, sizes and codes for the systolic max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

   localparam int DEPTH     = 64;
   localparam int KEY_W     = 32;
   localparam int COUNT_W   = 7;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;

   localparam logic [COUNT_W-1:0] DEPTH_COUNT    = COUNT_W'(DEPTH);
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(64);

   localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic signed [KEY_W-1:0] key_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [KEY_W-1:0] max_key;
      logic [COUNT_W-1:0]      entry_count;
   } rsp_type;

   typedef struct packed {
      logic                    insert;
      logic                    extract;
      logic signed [KEY_W-1:0] key;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: hdl/mpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Max priority queue cell
// One slot of the sorted chain: keeps its key, takes the broadcast key or its
// upper neighbor's key on insert, and its lower neighbor's key on extract.
// ----------------------------------------------------------------------------
module mpq_cell
   import mpq_pkg::*;
(
   input  wire logic                    clock,
   input  wire cell_ctl_type            ctl,
   input  wire logic                    occupied,
   input  wire logic                    prev_ge,
   input  wire logic signed [KEY_W-1:0] prev_key,
   input  wire logic signed [KEY_W-1:0] next_key,
   output      logic signed [KEY_W-1:0] key_out,
   output      logic                    ge_out
);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;

   assign ge_out  = occupied && (key_ff >= ctl.key);
   assign key_out = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctl.insert) begin
         if (ge_out) begin
            key_in = key_ff;
         end else if (prev_ge) begin
            key_in = ctl.key;
         end else begin
            key_in = prev_key;
         end
      end else if (ctl.extract) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule
`default_nettype wire

FILE: hdl/max_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Max priority queue
// The response is registered in the cycle after the request transfer.
// Throughput: one command per cycle while rsp_ready is high; every cell of
// the sorted chain updates in the same cycle; one chain update sets the rate.
// Reset clears the entry count and sets the capacity limit to 64; the key
// cells are not cleared and hold nothing observable until filled.
// ----------------------------------------------------------------------------
module max_priority_queue
   import mpq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire req_type            req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      rsp_type            rsp_data,
   input  wire logic               csr_write_enable,
   input  wire logic [COUNT_W-1:0] csr_write_data
);

   logic [COUNT_W-1:0]      capacity_limit_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [COUNT_W-1:0]      count_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_data_in;
   logic [COUNT_W-1:0]      cap;
   logic                    accept;
   cell_ctl_type            ctl;
   logic signed [KEY_W-1:0] keys [DEPTH];
   logic                    ge [DEPTH];

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cap       = (capacity_limit_ff > DEPTH_COUNT) ? DEPTH_COUNT : capacity_limit_ff;

   always_comb begin
      ctl.insert              = 1'b0;
      ctl.extract             = 1'b0;
      ctl.key                 = req_data.key_in;
      count_in                = count_ff;
      rsp_data_in.status      = ST_OK;
      rsp_data_in.max_key     = '0;
      case (req_data.cmd)
         CMD_INSERT: begin
            if (count_ff >= cap) begin
               rsp_data_in.status = ST_OVERFLOW;
            end else begin
               ctl.insert = accept;
               count_in   = count_ff + COUNT_W'(1);
            end
         end
         CMD_EXTRACT: begin
            if (count_ff == '0) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               rsp_data_in.max_key = keys[0];
               ctl.extract         = accept;
               count_in            = count_ff - COUNT_W'(1);
            end
         end
         CMD_PEEK: begin
            if (count_ff == '0) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               rsp_data_in.max_key = keys[0];
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.entry_count = count_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                    occupied;
      logic                    prev_ge;
      logic signed [KEY_W-1:0] prev_key;
      logic signed [KEY_W-1:0] next_key;

      assign occupied = count_ff > COUNT_W'(i);

      if (i == 0) begin : g_head
         assign prev_ge  = 1'b1;
         assign prev_key = ctl.key;
      end else begin : g_body
         assign prev_ge  = ge[i-1];
         assign prev_key = keys[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_key = keys[i];
      end else begin : g_link
         assign next_key = keys[i+1];
      end

      mpq_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .occupied (occupied),
         .prev_ge  (prev_ge),
         .prev_key (prev_key),
         .next_key (next_key),
         .key_out  (keys[i]),
         .ge_out   (ge[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_limit_ff <= CAPACITY_RESET;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_limit_ff <= csr_write_data;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The count never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT)
      else $error("entry count exceeds depth");

   // The two leading cells stay in descending order while both are held.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= COUNT_W'(2)) |-> (keys[0] >= keys[1]))
      else $error("head cells out of order");

   // A successful insert transfer raises the reported count by one.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.cmd == CMD_INSERT && count_ff < cap)
      |=> (rsp_valid && rsp_data.status == ST_OK
           && rsp_data.entry_count == $past(count_ff) + COUNT_W'(1)))
      else $error("insert count mismatch");

   // An overflow transfer leaves the count unchanged.
   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.cmd == CMD_INSERT && count_ff >= cap)
      |=> (count_ff == $past(count_ff) && rsp_data.status == ST_OVERFLOW))
      else $error("overflow changed the count");

endmodule
`default_nettype wire

FILE: tb/max_priority_queue_test.sv
// ----------------------------------------------------------------------------
// Max priority queue testbench
// Drives insert, extract, peek and unused commands through the valid/ready
// request channel and checks every response against a queue model that
// tracks the held keys and the capacity limit, under several idling mixes.
// ----------------------------------------------------------------------------
module max_priority_queue_test;
   import mpq_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RESPONSE_LATENCY = 1;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_SEND_GAP = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;

   logic signed [KEY_W-1:0] held_keys[$];
   logic [COUNT_W-1:0] capacity_model = CAPACITY_RESET;
   rsp_type expected_responses[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int errors = 0;
   int commands_accepted = 0;
   int responses_checked = 0;
   int overflows_seen = 0;
   int empties_seen = 0;

   max_priority_queue i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type compute_queue_response(input req_type command);
      rsp_type answer;
      logic [COUNT_W-1:0] room;
      int top;
      answer = '0;
      room = (capacity_model > DEPTH_COUNT) ? DEPTH_COUNT : capacity_model;
      case (command.cmd)
         CMD_INSERT: begin
            if (held_keys.size() >= room) begin
               answer.status = ST_OVERFLOW;
            end else begin
               held_keys.push_back(command.key_in);
            end
         end
         CMD_EXTRACT, CMD_PEEK: begin
            if (held_keys.size() == 0) begin
               answer.status = ST_EMPTY;
            end else begin
               top = 0;
               for (int i = 1; i < held_keys.size(); i++) begin
                  if (held_keys[i] > held_keys[top]) top = i;
               end
               answer.max_key = held_keys[top];
               if (command.cmd == CMD_EXTRACT) held_keys.delete(top);
            end
         end
         default: begin
         end
      endcase
      answer.entry_count = COUNT_W'(held_keys.size());
      return answer;
   endfunction

   function automatic logic signed [KEY_W-1:0] random_key();
      logic signed [KEY_W-1:0] k;
      case ($urandom_range(9))
         0: k = 32'h7FFF_FFFF;
         1: k = 32'h8000_0000;
         2, 3: k = $urandom_range(8) - 4;
         default: k = $urandom;
      endcase
      return k;
   endfunction

   always @(posedge clock) begin : track_transfers
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (csr_write_enable) capacity_model = csr_write_data;
         if (req_valid && req_ready) begin
            expected_responses.push_back(compute_queue_response(req_data));
            commands_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_responses.size() == 0) begin
               $display("%0t: response with no command outstanding, actual %0d %0d %0d",
                        $time, got.status, got.max_key, got.entry_count);
               errors++;
            end else begin
               want = expected_responses.pop_front();
               responses_checked++;
               if (want.status == ST_OVERFLOW) overflows_seen++;
               if (want.status == ST_EMPTY) empties_seen++;
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, got.status);
                  errors++;
               end
               if (got.max_key !== want.max_key) begin
                  $display("%0t: max_key expected %0d, actual %0d",
                           $time, want.max_key, got.max_key);
                  errors++;
               end
               if (got.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count expected %0d, actual %0d",
                           $time, want.entry_count, got.entry_count);
                  errors++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [KEY_W-1:0] key);
      int gap;
      req_type command;
      gap = 0;
      while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
      command.cmd = cmd;
      command.key_in = key;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= command;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic wait_for_all_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (RESPONSE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [COUNT_W-1:0] limit);
      wait_for_all_responses();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= limit;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      stall_pct = receiver_pct;
   endtask

   task automatic test_basic_commands();
      send_command(CMD_PEEK, $urandom);
      send_command(CMD_EXTRACT, $urandom);
      send_command(CMD_UNUSED, $urandom);
      send_command(CMD_INSERT, 32'h7FFF_FFFF);
      send_command(CMD_INSERT, 32'h8000_0000);
      send_command(CMD_INSERT, 32'h0000_0000);
      send_command(CMD_INSERT, 32'hFFFF_FFFF);
      send_command(CMD_INSERT, 32'sd1);
      send_command(CMD_INSERT, 32'sd1);
      send_command(CMD_UNUSED, $urandom);
      send_command(CMD_PEEK, $urandom);
      repeat (6) send_command(CMD_EXTRACT, $urandom);
      send_command(CMD_EXTRACT, $urandom);
      send_command(CMD_PEEK, $urandom);
      send_command(CMD_INSERT, 32'h5555_5555);
      send_command(CMD_INSERT, 32'hAAAA_AAAA);
      repeat (2) send_command(CMD_EXTRACT, $urandom);
   endtask

   task automatic test_capacity_limits();
      write_capacity(7'd0);
      repeat (2) send_command(CMD_INSERT, random_key());
      send_command(CMD_PEEK, $urandom);
      write_capacity(7'd1);
      repeat (2) send_command(CMD_INSERT, random_key());
      send_command(CMD_PEEK, $urandom);
      send_command(CMD_EXTRACT, $urandom);
      write_capacity(7'd127);
      repeat (DEPTH + 1) send_command(CMD_INSERT, random_key());
      send_command(CMD_PEEK, $urandom);
      // Lowering the limit below the held count keeps every entry.
      write_capacity(7'd3);
      send_command(CMD_INSERT, random_key());
      repeat (DEPTH - 2) send_command(CMD_EXTRACT, $urandom);
      repeat (2) send_command(CMD_INSERT, random_key());
      write_capacity(CAPACITY_RESET);
      repeat (4) send_command(CMD_EXTRACT, $urandom);
   endtask

   task automatic test_random_traffic(input int count);
      int insert_pct;
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 50;
               default: insert_pct = 15;
            endcase
         end
         if ($urandom_range(149) == 0) wait_for_all_responses();
         if ($urandom_range(99) < insert_pct) begin
            send_command(CMD_INSERT, random_key());
         end else begin
            pick = $urandom_range(99);
            if (pick < 70) send_command(CMD_EXTRACT, $urandom);
            else if (pick < 95) send_command(CMD_PEEK, $urandom);
            else send_command(CMD_UNUSED, $urandom);
         end
      end
   endtask

   task automatic test_response_hold_off();
      set_idling(0, 0);
      wait_for_all_responses();
      hold_cycles = 300;
      repeat (60) send_command(CMD_INSERT, random_key());
      repeat (20) send_command(($urandom_range(1) == 0) ? CMD_PEEK : CMD_EXTRACT, $urandom);
      wait_for_all_responses();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_commands();
      test_capacity_limits();

      set_idling(0, 0);
      test_random_traffic(400);
      write_capacity(7'd127);
      set_idling(85, 0);
      test_random_traffic(400);
      write_capacity(7'd9);
      set_idling(0, 85);
      test_random_traffic(400);
      write_capacity(COUNT_W'($urandom_range(1, DEPTH)));
      set_idling(13, 13);
      test_random_traffic(400);

      test_response_hold_off();
      wait_for_all_responses();

      $display("Run covered %0d commands and %0d checked responses, %0d overflow and %0d empty.",
               commands_accepted, responses_checked, overflows_seen, empties_seen);
      $display("Limits from 0 to 127, four idling mixes and a long response hold-off were used.");
      if (errors == 0 && expected_responses.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
